// ----- rtl/rprq_pkg.sv -----
`default_nettype none
package rprq_pkg;

   localparam int REQ_W  = 2;
   localparam int ID_W   = 5;
   localparam int PRIO_W = 7;
   localparam int RAND_W = 15;
   localparam int STAT_W = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT   = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_SCHEDULE = 2'd2,
      REQ_NOP      = 2'd3
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } status_code_type;

   typedef enum logic [1:0] {
      RK_PLAIN  = 2'd0,
      RK_EMPTY  = 2'd1,
      RK_KEEP   = 2'd2,
      RK_SWITCH = 2'd3
   } res_kind_type;

   typedef enum logic [1:0] {
      TGT_REQ  = 2'd0,
      TGT_PICK = 2'd1,
      TGT_CUR  = 2'd2
   } tsel_type;

   typedef struct packed {
      logic            latch;
      logic            walk_start;
      logic            step;
      logic            track;
      logic            sched_init;
      logic            tload;
      tsel_type        tsel;
      logic            unlink_wr;
      logic            link_wr_entry;
      logic            link_wr_prev;
      logic            out_load;
      res_kind_type    kind;
      status_code_type status;
   } cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         pid_ok;
      logic         pid_present;
      logic         cur_ok;
      logic         cur_present;
      logic         cur_running;
      logic         full;
      logic         head_nil;
      logic         cur_nil;
      logic         hit;
      logic         key_lt;
      logic         prev_nil;
      logic         preempt;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/rprq_if.sv -----
`default_nettype none
interface rprq_req_if import rprq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ID_W-1:0]   proc_id;
   logic [PRIO_W-1:0] proc_prio;
   logic [RAND_W-1:0] rand_value;
   logic [ID_W-1:0]   cur_pid;
   logic [PRIO_W-1:0] cur_prio;
   logic              cur_running;

   modport source (output valid, req_type, proc_id, proc_prio, rand_value, cur_pid,
                   cur_prio, cur_running, input ready);
   modport sink (input valid, req_type, proc_id, proc_prio, rand_value, cur_pid,
                 cur_prio, cur_running, output ready);
endinterface

interface rprq_rsp_if import rprq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   next_pid;
   logic              switched;
   logic              queue_empty;
   logic [STAT_W-1:0] status;

   modport source (output valid, next_pid, switched, queue_empty, status, input ready);
   modport sink (input valid, next_pid, switched, queue_empty, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/rprq_datapath.sv -----
`default_nettype none
module rprq_datapath import rprq_pkg::*; #(
   parameter int MAX_PROCS = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [ID_W-1:0]   proc_id,
   input  logic [PRIO_W-1:0] proc_prio,
   input  logic [RAND_W-1:0] rand_value,
   input  logic [ID_W-1:0]   cur_pid,
   input  logic [PRIO_W-1:0] cur_prio,
   input  logic              cur_running,
   output logic [ID_W-1:0]   next_pid,
   output logic              switched,
   output logic              queue_empty,
   output logic [STAT_W-1:0] status
);

   localparam int AW = $clog2(MAX_PROCS);
   localparam int PW = $clog2(MAX_PROCS + 1);
   localparam int FXW = PRIO_W + FRAC_BITS;
   localparam int CW = (FXW > RAND_W) ? FXW : RAND_W;
   localparam int IW = ((ID_W > PW) ? ID_W : PW) + 1;
   localparam logic [PW-1:0] NIL = PW'(MAX_PROCS);

   typedef struct packed {
      logic [PRIO_W-1:0] key;
      logic [PW-1:0]     nxt;
   } word_type;

   function automatic logic [CW-1:0] fx(input logic [PRIO_W-1:0] k);
      return CW'(k) << FRAC_BITS;
   endfunction

   word_type list_mem [MAX_PROCS];
   word_type rdata_ff;
   word_type mem_wdata;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic mem_we;

   logic [REQ_W-1:0]  rtype_ff;
   logic [ID_W-1:0]   pid_ff, cpid_ff;
   logic [PRIO_W-1:0] prio_ff, cprio_ff;
   logic [RAND_W-1:0] rand_ff;
   logic              crun_ff;

   logic [PW-1:0] head_ff, count_ff, cur_ff, prev_ff, tgt_ff;
   logic [PRIO_W-1:0] prev_key_ff, tgt_key_ff;
   logic [MAX_PROCS-1:0] present_ff;

   logic found_ff, done_ff;
   logic [PW-1:0] pick_ff, tail_ff;
   logic [PRIO_W-1:0] pkey_ff, tkey_ff;
   logic [PW-1:0] pick_sel;
   logic [PRIO_W-1:0] pkey_sel;
   logic [CW-1:0] rv_c, cfx;

   logic [ID_W-1:0]   next_pid_ff;
   logic              switched_ff, empty_ff;
   logic [STAT_W-1:0] status_ff;

   assign pick_sel = found_ff ? pick_ff : tail_ff;
   assign pkey_sel = found_ff ? pkey_ff : tkey_ff;
   assign rv_c     = CW'(rand_ff);
   assign cfx      = fx(cprio_ff);

   always_comb begin
      stat.req_code    = req_code_type'(rtype_ff);
      stat.pid_ok      = IW'(pid_ff) < IW'(MAX_PROCS);
      stat.pid_present = stat.pid_ok && present_ff[AW'(pid_ff)];
      stat.cur_ok      = IW'(cpid_ff) < IW'(MAX_PROCS);
      stat.cur_present = stat.cur_ok && present_ff[AW'(cpid_ff)];
      stat.cur_running = crun_ff;
      stat.full        = count_ff >= NIL;
      stat.head_nil    = head_ff == NIL;
      stat.cur_nil     = cur_ff == NIL;
      stat.hit         = cur_ff == tgt_ff;
      stat.key_lt      = rdata_ff.key < tgt_key_ff;
      stat.prev_nil    = prev_ff == NIL;
      stat.preempt     = crun_ff && (((cprio_ff < pkey_sel) && (rv_c < cfx)) ||
                                     ((cprio_ff > pkey_sel) && (rv_c > cfx)));
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(prev_ff);
      mem_wdata = '{key: prev_key_ff, nxt: tgt_ff};
      if (cmd.unlink_wr && (prev_ff != NIL)) begin
         mem_we    = 1'b1;
         mem_wdata = '{key: prev_key_ff, nxt: rdata_ff.nxt};
      end
      if (cmd.link_wr_entry) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(tgt_ff);
         mem_wdata = '{key: tgt_key_ff, nxt: cur_ff};
      end
      if (cmd.link_wr_prev) begin
         mem_we = 1'b1;
      end
      if (cmd.step) begin
         mem_raddr = AW'(rdata_ff.nxt);
      end else if (cmd.walk_start) begin
         mem_raddr = AW'(head_ff);
      end else begin
         mem_raddr = AW'(cur_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         list_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= list_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rtype_ff <= req_type;
         pid_ff   <= proc_id;
         prio_ff  <= proc_prio;
         rand_ff  <= rand_value;
         cpid_ff  <= cur_pid;
         cprio_ff <= cur_prio;
         crun_ff  <= cur_running;
      end
      if (cmd.tload) begin
         case (cmd.tsel)
            TGT_REQ: begin
               tgt_ff     <= PW'(pid_ff);
               tgt_key_ff <= prio_ff;
            end
            TGT_PICK: begin
               tgt_ff     <= pick_sel;
               tgt_key_ff <= pkey_sel;
            end
            TGT_CUR: begin
               tgt_ff     <= PW'(cpid_ff);
               tgt_key_ff <= cprio_ff;
            end
            default: begin
               tgt_ff     <= tgt_ff;
               tgt_key_ff <= tgt_key_ff;
            end
         endcase
      end
      if (cmd.walk_start) begin
         cur_ff  <= head_ff;
         prev_ff <= NIL;
      end
      if (cmd.step) begin
         prev_ff     <= cur_ff;
         prev_key_ff <= rdata_ff.key;
         cur_ff      <= rdata_ff.nxt;
      end
      if (cmd.sched_init) begin
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end
      if (cmd.step && cmd.track) begin
         tail_ff <= cur_ff;
         tkey_ff <= rdata_ff.key;
         if (!found_ff && (fx(rdata_ff.key) > rv_c)) begin
            found_ff <= 1'b1;
            pick_ff  <= cur_ff;
            pkey_ff  <= rdata_ff.key;
         end else if (found_ff && !done_ff) begin
            if (rdata_ff.key == pkey_ff) begin
               pick_ff <= cur_ff;
            end else begin
               done_ff <= 1'b1;
            end
         end
      end
      if (cmd.out_load) begin
         status_ff   <= cmd.status;
         next_pid_ff <= '0;
         switched_ff <= 1'b0;
         empty_ff    <= 1'b0;
         case (cmd.kind)
            RK_EMPTY: begin
               next_pid_ff <= cpid_ff;
               empty_ff    <= 1'b1;
            end
            RK_KEEP: begin
               next_pid_ff <= cpid_ff;
            end
            RK_SWITCH: begin
               next_pid_ff <= ID_W'(pick_sel);
               switched_ff <= 1'b1;
            end
            default: begin
               next_pid_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= NIL;
         count_ff   <= '0;
         present_ff <= '0;
      end else begin
         if (cmd.unlink_wr) begin
            if (prev_ff == NIL) begin
               head_ff <= rdata_ff.nxt;
            end
            present_ff[AW'(tgt_ff)] <= 1'b0;
            if (count_ff != '0) begin
               count_ff <= count_ff - PW'(1);
            end
         end
         if (cmd.link_wr_entry) begin
            if (prev_ff == NIL) begin
               head_ff <= tgt_ff;
            end
            present_ff[AW'(tgt_ff)] <= 1'b1;
            count_ff <= count_ff + PW'(1);
         end
      end
   end

   assign next_pid    = next_pid_ff;
   assign switched    = switched_ff;
   assign queue_empty = empty_ff;
   assign status      = status_ff;

endmodule
`default_nettype wire

// ----- rtl/rprq_ctrl.sv -----
`default_nettype none
module rprq_ctrl import rprq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_U_START, S_U_CHK, S_L_START, S_L_CHK, S_L_W1, S_L_W2,
      S_S_START, S_S_CHK, S_S_DEC, S_R_CHECK, S_FIN
   } state_type;

   typedef enum logic [1:0] {CTX_INS, CTX_REM, CTX_PICK, CTX_CUR} ctx_type;

   state_type       state_ff, state_in;
   ctx_type         ctx_ff, ctx_in;
   res_kind_type    kind_ff, kind_in;
   status_code_type code_ff, code_in;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            kind_in  = RK_PLAIN;
            code_in  = ST_OK;
            cmd.tsel = TGT_REQ;
            state_in = S_FIN;
            unique case (stat.req_code)
               REQ_INSERT: begin
                  if (!stat.pid_ok) begin
                     code_in = ST_FULL;
                  end else if (stat.pid_present) begin
                     cmd.tload = 1'b1;
                     ctx_in    = CTX_INS;
                     state_in  = S_U_START;
                  end else if (stat.full) begin
                     code_in = ST_FULL;
                  end else begin
                     cmd.tload = 1'b1;
                     ctx_in    = CTX_INS;
                     state_in  = S_L_START;
                  end
               end
               REQ_REMOVE: begin
                  if (!stat.pid_present) begin
                     code_in = ST_ABSENT;
                  end else begin
                     cmd.tload = 1'b1;
                     ctx_in    = CTX_REM;
                     state_in  = S_U_START;
                  end
               end
               REQ_SCHEDULE: begin
                  if (stat.head_nil) begin
                     kind_in = RK_EMPTY;
                  end else begin
                     state_in = S_S_START;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_U_START: begin
            cmd.walk_start = 1'b1;
            state_in       = S_U_CHK;
         end
         S_U_CHK: begin
            if (!stat.cur_nil && !stat.hit) begin
               cmd.step = 1'b1;
            end else begin
               cmd.unlink_wr = !stat.cur_nil;
               unique case (ctx_ff)
                  CTX_INS, CTX_CUR: state_in = S_L_START;
                  CTX_REM: state_in = S_FIN;
                  default: state_in = S_R_CHECK;
               endcase
            end
         end
         S_L_START: begin
            cmd.walk_start = 1'b1;
            state_in       = S_L_CHK;
         end
         S_L_CHK: begin
            if (!stat.cur_nil && stat.key_lt) begin
               cmd.step = 1'b1;
            end else begin
               state_in = S_L_W1;
            end
         end
         S_L_W1: begin
            cmd.link_wr_entry = 1'b1;
            state_in          = stat.prev_nil ? S_FIN : S_L_W2;
         end
         S_L_W2: begin
            cmd.link_wr_prev = 1'b1;
            state_in         = S_FIN;
         end
         S_S_START: begin
            cmd.walk_start = 1'b1;
            cmd.sched_init = 1'b1;
            state_in       = S_S_CHK;
         end
         S_S_CHK: begin
            if (stat.cur_nil) begin
               state_in = S_S_DEC;
            end else begin
               cmd.step  = 1'b1;
               cmd.track = 1'b1;
            end
         end
         S_S_DEC: begin
            if (stat.preempt) begin
               kind_in  = RK_KEEP;
               state_in = S_FIN;
            end else begin
               cmd.tload = 1'b1;
               cmd.tsel  = TGT_PICK;
               ctx_in    = CTX_PICK;
               kind_in   = RK_SWITCH;
               state_in  = S_U_START;
            end
         end
         S_R_CHECK: begin
            if (stat.cur_running && stat.cur_ok) begin
               cmd.tload = 1'b1;
               cmd.tsel  = TGT_CUR;
               ctx_in    = CTX_CUR;
               state_in  = stat.cur_present ? S_U_START : S_L_START;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.kind   = kind_ff;
            cmd.status = code_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctx_ff       <= CTX_INS;
         kind_ff      <= RK_PLAIN;
         code_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         kind_ff      <= kind_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted beat did not move to decode");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result loaded without valid");

   a_w2_prev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_L_W2) |-> !stat.prev_nil)
      else $error("predecessor write with no predecessor");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.unlink_wr && (cmd.link_wr_entry || cmd.link_wr_prev)))
      else $error("two list writes in one cycle");

endmodule
`default_nettype wire

// ----- rtl/random_priority_ready_queue_scheduler_core.sv -----
`default_nettype none
// Ready-queue scheduler that keeps up to MAX_PROCS process ids in a linked list ordered by
// ascending priority, held in a list memory with one read and one write port that is walked
// one entry per cycle. An insert of a present id walks twice. A schedule request walks the
// whole list once to find its candidate; unless the running process is kept, it then removes
// the candidate and, if a running process with a valid id is given, takes that process out of
// the set where present and inserts it again. One request is in work at a time, and a new one
// is taken while the previous result beat still waits on the response channel.
module random_priority_ready_queue_scheduler_core import rprq_pkg::*; #(
   parameter int MAX_PROCS = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   rprq_req_if.sink   req_bus,
   rprq_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   rprq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rprq_datapath #(
      .MAX_PROCS (MAX_PROCS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_type    (req_bus.req_type),
      .proc_id     (req_bus.proc_id),
      .proc_prio   (req_bus.proc_prio),
      .rand_value  (req_bus.rand_value),
      .cur_pid     (req_bus.cur_pid),
      .cur_prio    (req_bus.cur_prio),
      .cur_running (req_bus.cur_running),
      .next_pid    (rsp_bus.next_pid),
      .switched    (rsp_bus.switched),
      .queue_empty (rsp_bus.queue_empty),
      .status      (rsp_bus.status)
   );

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import rprq_pkg::*;

   localparam int NPROC = 32;
   localparam int FRAC = 8;
   localparam int NIL = NPROC;
   localparam int IDLE_LIMIT = 5000;

   typedef struct {
      req_code_type op;
      logic [ID_W-1:0] pid;
      logic [PRIO_W-1:0] prio;
      logic [RAND_W-1:0] rval;
      logic [ID_W-1:0] cpid;
      logic [PRIO_W-1:0] cprio;
      logic running;
   } sched_req_t;

   typedef struct {
      logic [ID_W-1:0] next_pid;
      logic switched;
      logic empty;
      status_code_type status;
   } sched_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rprq_req_if req_if ();
   rprq_rsp_if rsp_if ();

   random_priority_ready_queue_scheduler_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if.sink),
      .rsp_bus(rsp_if.source)
   );

   always #4 clock = ~clock;

   // Shadow copy of the ready list.
   logic [PRIO_W-1:0] ready_key [NPROC];
   int ready_next [NPROC];
   bit ready_present [NPROC];
   int ready_head = NIL;
   int ready_count = 0;

   sched_rsp_t pending_rsp [$];
   int errors = 0;
   bit no_idle = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;
   int n_insert = 0, n_remove = 0, n_sched = 0, n_switch = 0, n_empty = 0, n_rsp = 0;

   function automatic void ready_unlink(int id);
      int prev = NIL;
      int cur = ready_head;
      if (id >= NIL || !ready_present[id]) return;
      for (int n = 0; n < NPROC && cur < NIL; n++) begin
         if (cur == id) begin
            if (prev == NIL) ready_head = ready_next[cur];
            else ready_next[prev] = ready_next[cur];
            ready_present[cur] = 0;
            if (ready_count > 0) ready_count--;
            return;
         end
         prev = cur;
         cur = ready_next[cur];
      end
   endfunction

   function automatic void ready_link(int id, logic [PRIO_W-1:0] key);
      int prev = NIL;
      int cur = ready_head;
      for (int n = 0; n < NPROC && cur < NIL && ready_key[cur] < key; n++) begin
         prev = cur;
         cur = ready_next[cur];
      end
      ready_key[id] = key;
      ready_next[id] = cur;
      ready_present[id] = 1;
      if (prev == NIL) ready_head = id;
      else ready_next[prev] = id;
      ready_count++;
   endfunction

   function automatic sched_rsp_t predict_schedule(sched_req_t r);
      sched_rsp_t e;
      int tail, pick, kp, rv, cp;
      e = '{next_pid: '0, switched: 1'b0, empty: 1'b0, status: ST_OK};
      rv = int'(r.rval);
      cp = int'(r.cprio);
      case (r.op)
         REQ_INSERT: begin
            if (ready_present[r.pid]) begin
               ready_unlink(r.pid);
               ready_link(r.pid, r.prio);
            end else if (ready_count >= NPROC) e.status = ST_FULL;
            else ready_link(r.pid, r.prio);
         end
         REQ_REMOVE: begin
            if (!ready_present[r.pid]) e.status = ST_ABSENT;
            else ready_unlink(r.pid);
         end
         REQ_SCHEDULE: begin
            e.next_pid = r.cpid;
            if (ready_head >= NIL) e.empty = 1'b1;
            else begin
               tail = ready_head;
               for (int n = 0; n < NPROC && ready_next[tail] < NIL; n++)
                  tail = ready_next[tail];
               if (rv >= (int'(ready_key[tail]) << FRAC)) pick = tail;
               else begin
                  pick = ready_head;
                  for (int n = 0; n < NPROC && ready_next[pick] < NIL &&
                       (int'(ready_key[pick]) << FRAC) <= rv; n++)
                     pick = ready_next[pick];
                  for (int n = 0; n < NPROC && ready_next[pick] < NIL &&
                       ready_key[ready_next[pick]] == ready_key[pick]; n++)
                     pick = ready_next[pick];
               end
               kp = int'(ready_key[pick]);
               if (!(r.running && ((cp < kp && rv < (cp << FRAC)) ||
                                   (cp > kp && rv > (cp << FRAC))))) begin
                  ready_unlink(pick);
                  if (r.running) begin
                     ready_unlink(r.cpid);
                     if (ready_count < NPROC) ready_link(r.cpid, r.cprio);
                  end
                  e.next_pid = pick[ID_W-1:0];
                  e.switched = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   task automatic send_req(sched_req_t r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= r.op;
      req_if.proc_id <= r.pid;
      req_if.proc_prio <= r.prio;
      req_if.rand_value <= r.rval;
      req_if.cur_pid <= r.cpid;
      req_if.cur_prio <= r.cprio;
      req_if.cur_running <= r.running;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp.push_back(predict_schedule(r));
      case (r.op)
         REQ_INSERT: n_insert++;
         REQ_REMOVE: n_remove++;
         REQ_SCHEDULE: n_sched++;
         default: ;
      endcase
   endtask

   function automatic sched_req_t make_req(req_code_type op, int pid, int prio, int rval,
                                           int cpid, int cprio, bit running);
      sched_req_t r;
      r.op = op;
      r.pid = pid[ID_W-1:0];
      r.prio = prio[PRIO_W-1:0];
      r.rval = rval[RAND_W-1:0];
      r.cpid = cpid[ID_W-1:0];
      r.cprio = cprio[PRIO_W-1:0];
      r.running = running;
      return r;
   endfunction

   function automatic int present_id();
      int k;
      if (ready_count == 0) return $urandom_range(0, NPROC - 1);
      k = $urandom_range(0, ready_count - 1);
      for (int i = 0; i < NPROC; i++)
         if (ready_present[i]) begin
            if (k == 0) return i;
            k--;
         end
      return 0;
   endfunction

   function automatic int near_key_rand();
      int base;
      if ($urandom_range(0, 9) < 4 || ready_count == 0) return $urandom_range(0, 32767);
      base = int'(ready_key[present_id()]) << FRAC;
      case ($urandom_range(0, 2))
         0: return base;
         1: return (base > 0) ? base - $urandom_range(1, 255) : 0;
         default: return base + $urandom_range(1, 255);
      endcase
   endfunction

   task automatic random_item();
      int sel, cprio;
      sel = $urandom_range(0, 99);
      cprio = ($urandom_range(0, 1) && ready_count > 0) ? ready_key[present_id()]
                                                        : $urandom_range(0, 127);
      if (sel < 35)
         send_req(make_req(REQ_INSERT, $urandom_range(0, 31), $urandom_range(0, 127),
                           $urandom_range(0, 32767), $urandom_range(0, 31),
                           $urandom_range(0, 127), $urandom_range(0, 1)));
      else if (sel < 50)
         send_req(make_req(REQ_REMOVE, ($urandom_range(0, 3) != 0) ? present_id()
                                                                   : $urandom_range(0, 31),
                           $urandom_range(0, 127), $urandom_range(0, 32767),
                           $urandom_range(0, 31), $urandom_range(0, 127),
                           $urandom_range(0, 1)));
      else if (sel < 96)
         send_req(make_req(REQ_SCHEDULE, $urandom_range(0, 31), $urandom_range(0, 127),
                           near_key_rand(), ($urandom_range(0, 4) == 0) ? present_id()
                                                                        : $urandom_range(0, 31),
                           cprio, $urandom_range(0, 3) != 0));
      else
         send_req(make_req(REQ_NOP, $urandom_range(0, 31), $urandom_range(0, 127),
                           $urandom_range(0, 32767), $urandom_range(0, 31),
                           $urandom_range(0, 127), $urandom_range(0, 1)));
   endtask

   task automatic test_empty_and_nop();
      send_req(make_req(REQ_SCHEDULE, 0, 0, 0, 7, 10, 1));
      send_req(make_req(REQ_NOP, 31, 127, 32767, 31, 127, 1));
      send_req(make_req(REQ_REMOVE, 5, 0, 0, 0, 0, 0));
   endtask

   task automatic test_insert_remove();
      send_req(make_req(REQ_INSERT, 0, 0, 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 31, 127, 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 3, 40, 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 4, 40, 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 5, 40, 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 0, 90, 0, 0, 0, 0));
      send_req(make_req(REQ_REMOVE, 31, 0, 0, 0, 0, 0));
      send_req(make_req(REQ_REMOVE, 31, 0, 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 31, 127, 0, 0, 0, 0));
   endtask

   task automatic test_schedule_rules();
      // Largest key reached, then the round robin among equal keys.
      send_req(make_req(REQ_SCHEDULE, 0, 0, 32767, 20, 60, 0));
      send_req(make_req(REQ_SCHEDULE, 0, 0, 10 << FRAC, 21, 60, 1));
      send_req(make_req(REQ_SCHEDULE, 0, 0, 10 << FRAC, 22, 50, 1));
      // The running process is kept on either side of the candidate's key.
      send_req(make_req(REQ_SCHEDULE, 0, 0, 20 << FRAC, 23, 30, 1));
      send_req(make_req(REQ_SCHEDULE, 0, 0, (100 << FRAC) + 1, 23, 100, 1));
      // The running process is already in the set; it is first kept, then replaced and reinserted.
      send_req(make_req(REQ_SCHEDULE, 0, 0, 0, 0, 5, 1));
      send_req(make_req(REQ_SCHEDULE, 0, 0, 0, 0, 0, 1));
      send_req(make_req(REQ_SCHEDULE, 0, 0, 40 << FRAC, 0, 0, 1));
   endtask

   task automatic test_full_set();
      no_idle = 1;
      for (int i = 0; i < NPROC; i++)
         send_req(make_req(REQ_INSERT, i, $urandom_range(0, 127), 0, 0, 0, 0));
      send_req(make_req(REQ_INSERT, 9, 127, 0, 0, 0, 0));
      send_req(make_req(REQ_SCHEDULE, 0, 0, $urandom_range(0, 32767), 9, 64, 1));
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      hold_rsp = 1;
      for (int i = 0; i < 12; i++) random_item();
      hold_rsp = 0;
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 100) no_idle = 1;
         if (i % 200 == 150) no_idle = 0;
         random_item();
      end
      no_idle = 0;
   endtask

   // Result side handshake, with random stalls and long holds while hold_rsp is set.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            stall = 0;
            while (stall < 400) begin
               @(posedge clock);
               stall++;
            end
         end
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   always @(posedge clock) begin
      sched_rsp_t e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (e.switched) n_switch++;
            if (e.empty) n_empty++;
            if (rsp_if.next_pid !== e.next_pid) begin
               $error("next_pid expected %0d actual %0d", e.next_pid, rsp_if.next_pid);
               errors++;
            end
            if (rsp_if.switched !== e.switched) begin
               $error("switched expected %0d actual %0d", e.switched, rsp_if.switched);
               errors++;
            end
            if (rsp_if.queue_empty !== e.empty) begin
               $error("queue_empty expected %0d actual %0d", e.empty, rsp_if.queue_empty);
               errors++;
            end
            if (rsp_if.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_if.status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_rsp.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.req_type <= REQ_NOP;
      req_if.proc_id <= '0;
      req_if.proc_prio <= '0;
      req_if.rand_value <= '0;
      req_if.cur_pid <= '0;
      req_if.cur_prio <= '0;
      req_if.cur_running <= 1'b0;
      for (int i = 0; i < NPROC; i++) begin
         ready_next[i] = NIL;
         ready_present[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_nop();
      test_insert_remove();
      test_schedule_rules();
      test_full_set();
      test_backpressure();
      test_random(1350);
      req_if.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d inserts, %0d removes, %0d schedules (%0d switches, %0d empty)",
               n_insert, n_remove, n_sched, n_switch, n_empty);
      $display("checked %0d result beats with %0d mismatches", n_rsp, errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
